// File: rtl/axis_response_curve_lookup_core_assert.svh
// Assertion macros for the axis response curve lookup core.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef AXIS_RESPONSE_CURVE_LOOKUP_CORE_ASSERT_SVH
`define AXIS_RESPONSE_CURVE_LOOKUP_CORE_ASSERT_SVH

// Checked outside reset.
`define ARCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define ARCL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/arcl_pkg.sv
// Shared types and constants for the axis response curve lookup core.
// No dependencies.
package arcl_pkg;

  localparam int unsigned IndexBitsDefault = 16;
  localparam int unsigned ValueW           = 16;
  localparam int unsigned CfgIdxW          = 8;

  localparam logic [ValueW-1:0] FoldCenter = 16'h7FFF;
  localparam logic [31:0]       RoundHalf  = 32'h0000_8000;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  localparam logic [CfgIdxW-1:0] RegScale        = 8'd0;
  localparam logic [CfgIdxW-1:0] RegMirrorCenter = 8'd1;
  localparam logic [CfgIdxW-1:0] RegMirrorX      = 8'd2;
  localparam logic [CfgIdxW-1:0] RegInvert       = 8'd3;

  typedef struct packed {
    logic [ValueW-1:0] scale;
    logic              mirror_center;
    logic              mirror_x;
    logic              invert;
  } arcl_cfg_t;

endpackage

// File: rtl/arcl_curve_ram.sv
// Curve table storage: one write port, one registered read port.
// Depends on arcl_pkg for the entry width.
module arcl_curve_ram
  import arcl_pkg::*;
#(
  parameter int unsigned IndexBits = IndexBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [IndexBits-1:0] waddr_i,
  input  logic [ValueW-1:0]    wdata_i,
  input  logic                 re_i,
  input  logic [IndexBits-1:0] raddr_i,
  output logic [ValueW-1:0]    rdata_o
);

  localparam int unsigned Depth = 1 << IndexBits;

  logic [ValueW-1:0] mem_q [Depth];
  logic [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/arcl_shaper.sv
// Value path after the table read: center fold, invert, rounded gain.
// Depends on arcl_pkg for the config struct and constants.
module arcl_shaper
  import arcl_pkg::*;
(
  input  arcl_cfg_t         cfg_i,
  input  logic [ValueW-1:0] raw_i,
  input  logic              fold_hi_i,
  output logic [ValueW-1:0] value_o
);

  logic [ValueW-1:0] half;
  logic [ValueW-1:0] folded;
  logic [ValueW-1:0] inv;
  logic [31:0]       prod;
  logic [31:0]       rounded;

  always_comb begin
    half = {1'b0, raw_i[ValueW-1:1]};
    if (cfg_i.mirror_center) begin
      // upper half sits above center, lower half below
      folded = fold_hi_i ? (FoldCenter + half) : (FoldCenter - half);
    end else begin
      folded = raw_i;
    end
    inv     = cfg_i.invert ? ~folded : folded;
    prod    = 32'(inv) * 32'(cfg_i.scale);
    rounded = prod + RoundHalf;
    value_o = (cfg_i.scale != '0) ? rounded[31:16] : inv;
  end

endmodule

// File: rtl/axis_response_curve_lookup_core.sv
// Axis response curve lookup core: top level with handshake, config and pipeline.
// Depends on arcl_pkg, arcl_curve_ram, arcl_shaper and the assertion header.
//
// Accepts one transaction per clock while in_ready is high. A write
// transaction (op 0) stores entry_value at index into a 2^INDEX_BITS x 16
// curve table and returns nothing. A lookup transaction (op 1) returns one
// curve_value, through the read stage and then the output register. The accept
// cycle computes the table address (mirror-x map, then the mirror-center map),
// and the table is read through its registered read port at the accepting edge.
// The read stage then folds, inverts and applies the rounded gain into the output
// register. Throughput is one transaction per cycle, bounded by the single table
// read port; a stalled output only holds the input side once both pipeline
// stages are full. Index bits above INDEX_BITS are ignored.
// The table has no reset and no clearing pass; reading an entry that was
// never written gives an undefined value. Configuration registers (scale,
// mirror_center, mirror_x, invert at indexes 0..3) reset to zero and are
// always ready; writes to other indexes are dropped. Change them only while
// no lookup is in flight.
module axis_response_curve_lookup_core
  import arcl_pkg::*;
#(
  parameter int unsigned INDEX_BITS = IndexBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [ValueW-1:0]  index_i,
  input  logic [ValueW-1:0]  entry_value_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ValueW-1:0]  curve_value_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ValueW-1:0]  cfg_value_i
);

`include "axis_response_curve_lookup_core_assert.svh"

  // Mirror map: low half -> S-2-2i, high half -> 2i mod S.
  function automatic logic [INDEX_BITS-1:0] mirror_idx(input logic [INDEX_BITS-1:0] i);
    logic [INDEX_BITS-2:0] lo;
    begin
      lo = i[INDEX_BITS-1] ? i[INDEX_BITS-2:0] : ~i[INDEX_BITS-2:0];
      return {lo, 1'b0};
    end
  endfunction

  arcl_cfg_t cfg_q, cfg_d;

  logic                  in_accept;
  logic                  is_lookup;
  logic                  out_adv;
  logic [INDEX_BITS-1:0] idx;
  logic [INDEX_BITS-1:0] idx_x;
  logic [INDEX_BITS-1:0] raddr;

  logic                  s1_valid_q, s1_valid_d;
  logic                  fold_hi_q;
  logic [ValueW-1:0]     raw_data;
  logic [ValueW-1:0]     shaped;

  logic                  out_valid_q, out_valid_d;
  logic [ValueW-1:0]     curve_value_q;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegScale:        cfg_d.scale         = cfg_value_i;
        RegMirrorCenter: cfg_d.mirror_center = cfg_value_i[0];
        RegMirrorX:      cfg_d.mirror_x      = cfg_value_i[0];
        RegInvert:       cfg_d.invert        = cfg_value_i[0];
        default:         ; // unknown register, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ------------------------------------------------------------- handshake
  // Output register frees up when empty or being drained this cycle; the
  // read stage then moves on, so the input side only stalls when both are
  // occupied and the consumer holds off.
  assign out_adv    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_adv;
  assign in_accept  = in_valid_i && in_ready_o;
  assign is_lookup  = (op_e'(op_i) == OP_LOOKUP);

  // ---------------------------------------------------------- address path
  // mirror-x remaps first, then mirror-center reads the mirrored point of
  // that index; the fold direction follows the half of the remapped index.
  assign idx   = index_i[INDEX_BITS-1:0];
  assign idx_x = cfg_q.mirror_x ? mirror_idx(idx) : idx;
  assign raddr = cfg_q.mirror_center ? mirror_idx(idx_x) : idx_x;

  arcl_curve_ram #(
    .IndexBits (INDEX_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept && !is_lookup),
    .waddr_i (idx),
    .wdata_i (entry_value_i),
    .re_i    (in_accept && is_lookup),
    .raddr_i (raddr),
    .rdata_o (raw_data)
  );

  // ------------------------------------------------------------ read stage
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = in_accept && is_lookup;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && is_lookup) begin
      fold_hi_q <= idx_x[INDEX_BITS-1];
    end
  end

  // ---------------------------------------------------------- value stage
  arcl_shaper u_shaper (
    .cfg_i     (cfg_q),
    .raw_i     (raw_data),
    .fold_hi_i (fold_hi_q),
    .value_o   (shaped)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      curve_value_q <= shaped;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign curve_value_o = curve_value_q;

  // ------------------------------------------------------------ assertions
  `ARCL_ASSERT(a_stall_only_when_full, !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i), "input stalled with room in pipeline")
  `ARCL_ASSERT(a_write_no_result, (in_accept && !is_lookup) |=> !s1_valid_q, "write transaction produced a read stage entry")
  `ARCL_ASSERT(a_lookup_enters, (in_accept && is_lookup) |=> s1_valid_q, "lookup transaction lost at read stage")
  // an edge seen in reset clears the pipeline for the next edge
  `ARCL_ASSERT_RST(a_reset_empty, !rst_ni |=> (!s1_valid_q && !out_valid_q), "pipeline not empty after reset")

endmodule

// File: tb/arcl_curve_checker.sv
// Scoreboard for the axis response curve lookup core: tracks the curve table and registers.
// Depends on arcl_pkg; only observes the input, result and register channels.
module arcl_curve_checker
  import arcl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               op_i,
  input  logic [ValueW-1:0]  index_i,
  input  logic [ValueW-1:0]  entry_value_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [ValueW-1:0]  curve_value_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ValueW-1:0]  cfg_value_i,
  input  logic               end_check_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  logic [ValueW-1:0] curve_mem [0:(1 << IndexBitsDefault) - 1];
  logic [ValueW-1:0] gain;
  logic              center_fold;
  logic              x_mirror;
  logic              complement;
  logic [ValueW-1:0] expected_curve [$];
  int                mismatches = 0;
  bit                leftovers_done = 1'b0;

  // low half -> 65534 - 2i, high half -> 2i - 65536
  function automatic logic [ValueW-1:0] fold_index(input logic [ValueW-1:0] i);
    if (i[ValueW-1]) return {i[ValueW-2:0], 1'b0};
    return 16'hFFFE - {i[ValueW-2:0], 1'b0};
  endfunction

  function automatic logic [ValueW-1:0] shaped_curve(input logic [ValueW-1:0] index);
    logic [ValueW-1:0] addr;
    logic [ValueW-1:0] half;
    logic [ValueW-1:0] v;
    logic [31:0]       prod;
    addr = x_mirror ? fold_index(index) : index;
    if (center_fold) begin
      half = curve_mem[fold_index(addr)] >> 1;
      v = addr[ValueW-1] ? FoldCenter + half : FoldCenter - half;
    end else begin
      v = curve_mem[addr];
    end
    if (complement) v = ~v;
    if (gain != '0) begin
      prod = 32'(v) * 32'(gain) + RoundHalf;
      v = prod[31:16];
    end
    return v;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] curve check: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [ValueW-1:0] want;
    if (!rst_ni) begin
      gain = '0;
      center_fold = 1'b0;
      x_mirror = 1'b0;
      complement = 1'b0;
      expected_curve.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegScale:        gain = cfg_value_i;
          RegMirrorCenter: center_fold = cfg_value_i[0];
          RegMirrorX:      x_mirror = cfg_value_i[0];
          RegInvert:       complement = cfg_value_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_curve.size() == 0) begin
          report($sformatf("unexpected curve_value %h", curve_value_i));
        end else begin
          want = expected_curve.pop_front();
          if (curve_value_i !== want)
            report($sformatf("curve_value %h, expected %h", curve_value_i, want));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (op_i == OP_WRITE) curve_mem[index_i] = entry_value_i;
        else expected_curve.push_back(shaped_curve(index_i));
      end
      if (end_check_i && !leftovers_done) begin
        foreach (expected_curve[k])
          report($sformatf("missing curve_value, expected %h", expected_curve[k]));
        leftovers_done = 1'b1;
      end
    end
    pending_o <= expected_curve.size();
    fail_count_o <= mismatches;
  end

endmodule

// File: tb/axis_response_curve_lookup_core_tb.sv
// Testbench top for the axis response curve lookup core: stimulus, idling and verdict.
// Depends on arcl_pkg, the core RTL and arcl_curve_checker, which does all the checking.
module axis_response_curve_lookup_core_tb;
  import arcl_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               op_i = 1'b0;
  logic [ValueW-1:0]  index_i = '0;
  logic [ValueW-1:0]  entry_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [ValueW-1:0]  curve_value_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [ValueW-1:0]  cfg_value_i = '0;

  logic end_check = 1'b0;
  int   pending_curves;
  int   fail_count;

  // idling on both sides; cleared for the final phase
  bit stall_en = 1'b1;
  int ready_hold = 0;

  // Addresses that hold a known value. Lookups are steered so that the entry
  // actually read is always one of these (the table has no reset). The first
  // entries of each list are the corner addresses of the directed part.
  bit                written_map [0:(1 << IndexBitsDefault) - 1];
  logic [ValueW-1:0] written_any [$];
  logic [ValueW-1:0] written_even [$];
  // mirror flags currently programmed, needed to steer lookups
  logic              mode_center = 1'b0;
  logic              mode_xmirror = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  axis_response_curve_lookup_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .index_i       (index_i),
    .entry_value_i (entry_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .curve_value_o (curve_value_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_value_i   (cfg_value_i)
  );

  arcl_curve_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .op_i          (op_i),
    .index_i       (index_i),
    .entry_value_i (entry_value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .curve_value_i (curve_value_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_value_i   (cfg_value_i),
    .end_check_i   (end_check),
    .pending_o     (pending_curves),
    .fail_count_o  (fail_count)
  );

  // Result side: ready drops in random bursts, with runs of ready high in
  // between. One assignment per edge.
  always @(posedge clk_i) begin
    if (stall_en && ready_hold == 0 && $urandom_range(0, 5) == 0)
      ready_hold = $urandom_range(1, 5);
    if (ready_hold > 0) begin
      out_ready_i <= 1'b0;
      ready_hold--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // One input transaction. Valid is held until accepted; an idle burst, if
  // any, comes before the item is offered.
  task automatic send_item(input op_e op, input logic [ValueW-1:0] index,
                           input logic [ValueW-1:0] value);
    if (stall_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    index_i <= index;
    entry_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_point(input logic [ValueW-1:0] addr, input logic [ValueW-1:0] value);
    send_item(OP_WRITE, addr, value);
    if (!written_map[addr]) begin
      written_map[addr] = 1'b1;
      written_any.push_back(addr);
      if (!addr[0]) written_even.push_back(addr);
    end
  endtask

  // Drain: input lowered, all lookups answered, then an idle wait before
  // returning.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_curves != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Valid stays high across back-to-back register writes; the caller lowers it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ValueW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_value_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_curve_mode(input logic [ValueW-1:0] gain, input logic center,
                                input logic xmirror, input logic complement);
    logic [14:0] junk;
    wait_idle();
    write_reg(RegScale, gain);
    // one-bit registers get random upper bits, which must be dropped
    junk = 15'($urandom);
    write_reg(RegMirrorCenter, {junk, center});
    junk = 15'($urandom);
    write_reg(RegMirrorX, {junk, xmirror});
    junk = 15'($urandom);
    write_reg(RegInvert, {junk, complement});
    // index past the register map: must change nothing
    write_reg(CfgIdxW'($urandom_range(4, 255)), 16'($urandom));
    cfg_valid_i <= 1'b0;
    mode_center = center;
    mode_xmirror = xmirror;
  endtask

  // Index whose mirror map lands on the even address a (two choices).
  function automatic logic [ValueW-1:0] fold_source(input logic [ValueW-1:0] a, input bit upper);
    return upper ? {1'b1, a[ValueW-1:1]} : 16'h7FFF - {1'b0, a[ValueW-1:1]};
  endfunction

  // Pick a lookup index whose table read hits a written entry. The mirror
  // map only reaches even addresses; with both mirrors on, the middle
  // address must itself be even, which fixes the half of the first step.
  function automatic logic [ValueW-1:0] lookup_index();
    logic [ValueW-1:0] a;
    if (mode_center || mode_xmirror) begin
      if ($urandom_range(0, 5) == 0) a = written_even[$urandom_range(0, 4)];
      else a = written_even[$urandom_range(0, written_even.size() - 1)];
      if (mode_center && mode_xmirror) a = fold_source(a, a[1] == 1'b0);
      return fold_source(a, 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 5) == 0) return written_any[$urandom_range(0, 7)];
    return written_any[$urandom_range(0, written_any.size() - 1)];
  endfunction

  // Curve points biased toward the value extremes and the fold center.
  function automatic logic [ValueW-1:0] curve_point();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mixed writes and lookups; some writes overwrite known points.
  task automatic run_traffic(input int count);
    repeat (count) begin
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 3) == 0)
          write_point(written_any[$urandom_range(0, written_any.size() - 1)], curve_point());
        else
          write_point(16'($urandom), curve_point());
      end else begin
        send_item(OP_LOOKUP, lookup_index(), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corner indexes with extreme values, read back under the
    // reset configuration (no transform), then an overwrite.
    write_point(16'h0000, 16'h0000);
    write_point(16'hFFFF, 16'hFFFF);
    write_point(16'h0001, 16'h8000);
    write_point(16'h7FFF, 16'h7FFF);
    write_point(16'h8000, 16'hFFFF);
    write_point(16'hFFFE, 16'h0001);
    write_point(16'h0002, 16'hFFFE);
    write_point(16'h7FFE, 16'h1234);
    send_item(OP_LOOKUP, 16'h0000, 16'hFFFF);
    send_item(OP_LOOKUP, 16'hFFFF, 16'h0000);
    send_item(OP_LOOKUP, 16'h0001, 16'h0000);
    send_item(OP_LOOKUP, 16'h7FFF, 16'h0000);
    send_item(OP_LOOKUP, 16'h8000, 16'h0000);
    send_item(OP_LOOKUP, 16'hFFFE, 16'h0000);
    send_item(OP_LOOKUP, 16'h0002, 16'h0000);
    send_item(OP_LOOKUP, 16'h7FFE, 16'h0000);
    write_point(16'h0000, 16'hFFFF);
    send_item(OP_LOOKUP, 16'h0000, 16'h0000);

    // Random phases, each under its own register setting: gain extremes,
    // every flag alone and all together.
    set_curve_mode(16'hFFFF, 1'b0, 1'b0, 1'b1);
    run_traffic(190);
    set_curve_mode(16'h0001, 1'b1, 1'b0, 1'b0);
    run_traffic(190);
    set_curve_mode(16'h0000, 1'b0, 1'b1, 1'b0);
    run_traffic(190);
    set_curve_mode(16'h8000, 1'b1, 1'b1, 1'b1);
    run_traffic(190);
    set_curve_mode(16'($urandom), 1'b1, 1'b0, 1'b1);
    run_traffic(190);
    set_curve_mode(16'h0000, 1'b0, 1'b1, 1'b1);
    run_traffic(190);
    set_curve_mode(16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    run_traffic(190);
    // last phase at full rate, no idling on either side
    stall_en = 1'b0;
    set_curve_mode(16'h0000, 1'b0, 1'b0, 1'b0);
    run_traffic(190);

    wait_idle();
    end_check <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/arcl_pkg.sv
rtl/arcl_curve_ram.sv
rtl/arcl_shaper.sv
rtl/axis_response_curve_lookup_core.sv
tb/arcl_curve_checker.sv
tb/axis_response_curve_lookup_core_tb.sv
